### rtl/lpc_pkg.sv
// ----------------------------------------------------------------------------
// lpc_pkg
// Shared types and constants of the lidar point colouriser: reset values
// of the camera registers, the fixed extrinsic matrix and register indexes.
// ----------------------------------------------------------------------------
package lpc_pkg;

    localparam int IMG_WIDTH_DEF  = 640;
    localparam int IMG_HEIGHT_DEF = 480;

    localparam logic [19:0]        FOCAL_X_RST  = 20'd154515;
    localparam logic [19:0]        FOCAL_Y_RST  = 20'd154583;
    localparam logic [19:0]        CENTER_X_RST = 20'd80946;
    localparam logic [19:0]        CENTER_Y_RST = 20'd63044;
    localparam logic signed [31:0] MIN_FWD_RST  = 32'sd16384;

    // extrinsic matrix in units of 2^-20
    localparam int EXT [0:2][0:3] = '{
        '{   -3334, -1048492,   -12814,  46546 },
        '{   16200,    12761, -1048377, -34760 },
        '{ 1048450,    -3523,    16159, -99961 }
    };

    typedef enum logic [2:0] {
        REG_FOCAL_X  = 3'd0,
        REG_FOCAL_Y  = 3'd1,
        REG_CENTER_X = 3'd2,
        REG_CENTER_Y = 3'd3,
        REG_MIN_FWD  = 3'd4
    } t_reg_idx;

    typedef struct packed {
        logic               is_wr;
        logic               fwd;
        logic               fe;
        logic signed [31:0] x;
        logic signed [31:0] y;
        logic signed [31:0] z;
        logic [9:0]         wcol;
        logic [8:0]         wrow;
        logic [23:0]        rgb;
    } t_pipe;

endpackage

### rtl/lidar_point_camera_colorize_top.sv
// ----------------------------------------------------------------------------
// lidar_point_camera_colorize_top
// Pixel store of one camera frame; lidar points are projected through the
// folded camera matrix, divided by depth and coloured from the store.
// ----------------------------------------------------------------------------
// path: side-band, products, sums, magnitudes, precheck, divider stages,
//   address, store read, result; the quotient has QB = clog2(max(IMG_WIDTH, IMG_HEIGHT)) + 1 bits
// throughput: one transaction per cycle; the divider is pipelined one quotient
//   bit per stage, each transaction makes one store access, a stalled result
//   holds the whole pipeline
// reset: synchronous, clears pipeline valids and camera registers; the
//   pixel store holds no defined content until written
// ----------------------------------------------------------------------------
module lidar_point_camera_colorize_top #(
    parameter int IMG_WIDTH  = lpc_pkg::IMG_WIDTH_DEF,
    parameter int IMG_HEIGHT = lpc_pkg::IMG_HEIGHT_DEF
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    output logic               o_stall,
    input  logic               i_req_type,
    input  logic [9:0]         i_write_col,
    input  logic [8:0]         i_write_row,
    input  logic [7:0]         i_write_red,
    input  logic [7:0]         i_write_green,
    input  logic [7:0]         i_write_blue,
    input  logic signed [31:0] i_point_x,
    input  logic signed [31:0] i_point_y,
    input  logic signed [31:0] i_point_z,
    input  logic               i_frame_end,
    output logic               o_valid,
    input  logic               i_stall,
    output logic               o_hit,
    output logic               o_frame_done,
    output logic [9:0]         o_image_col,
    output logic [8:0]         o_image_row,
    output logic [7:0]         o_color_red,
    output logic [7:0]         o_color_green,
    output logic [7:0]         o_color_blue,
    output logic signed [31:0] o_out_x,
    output logic signed [31:0] o_out_y,
    output logic signed [31:0] o_out_z,
    input  logic               i_cfg_valid,
    output logic               o_cfg_ready,
    input  logic [2:0]         i_cfg_index,
    input  logic [31:0]        i_cfg_data
);

    localparam int MAXD  = (IMG_WIDTH > IMG_HEIGHT) ? IMG_WIDTH : IMG_HEIGHT;
    localparam int QB    = $clog2(MAXD) + 1;
    localparam int DEPTH = IMG_WIDTH * IMG_HEIGHT;
    localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int NS    = QB + 7;
    localparam int DW    = 64 + QB;

    logic en;
    logic accept;

    logic [19:0]        r_fx, r_fy, r_cx, r_cy;
    logic signed [31:0] r_min_fwd;
    logic signed [31:0] r_k [0:2][0:3];
    logic signed [31:0] n_k [0:2][0:3];

    logic [NS-1:0]      r_v;
    lpc_pkg::t_pipe     r_pl [0:NS-1];

    logic signed [63:0] r_prod [0:2][0:2];
    logic signed [63:0] r_n [0:2];
    logic [63:0]        r_a0, r_a1, r_d;
    logic               r_neg0, r_neg1, r_pos;

    logic [63:0]        r_rem0 [0:QB];
    logic [63:0]        r_rem1 [0:QB];
    logic [QB-1:0]      r_q0 [0:QB];
    logic [QB-1:0]      r_q1 [0:QB];
    logic [63:0]        r_dd [0:QB];
    logic               r_ok [0:QB];
    logic               r_ng0 [0:QB];
    logic               r_ng1 [0:QB];

    logic               r_hit_a;
    logic [QB-1:0]      r_col_a, r_row_a;
    logic [AW-1:0]      r_addr;
    logic               r_we;

    logic [23:0]        mem [0:DEPTH-1];
    logic [23:0]        r_rd;
    logic               r_hit_m;
    logic [QB-1:0]      r_col_m, r_row_m;

    assign en          = !(o_valid && i_stall);
    assign o_stall     = !en;
    assign accept      = i_valid && en;
    assign o_cfg_ready = 1'b1;

    // camera registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fx      <= lpc_pkg::FOCAL_X_RST;
            r_fy      <= lpc_pkg::FOCAL_Y_RST;
            r_cx      <= lpc_pkg::CENTER_X_RST;
            r_cy      <= lpc_pkg::CENTER_Y_RST;
            r_min_fwd <= lpc_pkg::MIN_FWD_RST;
        end else if (i_cfg_valid) begin
            unique case (lpc_pkg::t_reg_idx'(i_cfg_index))
                lpc_pkg::REG_FOCAL_X:  r_fx      <= i_cfg_data[19:0];
                lpc_pkg::REG_FOCAL_Y:  r_fy      <= i_cfg_data[19:0];
                lpc_pkg::REG_CENTER_X: r_cx      <= i_cfg_data[19:0];
                lpc_pkg::REG_CENTER_Y: r_cy      <= i_cfg_data[19:0];
                lpc_pkg::REG_MIN_FWD:  r_min_fwd <= $signed(i_cfg_data);
                default: ;
            endcase
        end
    end

    // folded camera matrix, rounded half up to 2^-16
    always_comb begin
        logic signed [43:0] t0, t1, t2;
        for (int j = 0; j < 4; j++) begin
            t0 = 44'($signed({1'b0, r_fx})) * 44'(lpc_pkg::EXT[0][j])
               + 44'($signed({1'b0, r_cx})) * 44'(lpc_pkg::EXT[2][j]);
            t1 = 44'($signed({1'b0, r_fy})) * 44'(lpc_pkg::EXT[1][j])
               + 44'($signed({1'b0, r_cy})) * 44'(lpc_pkg::EXT[2][j]);
            t2 = 44'(lpc_pkg::EXT[2][j]) * 44'sd256;
            n_k[0][j] = 32'((t0 + 44'sd2048) >>> 12);
            n_k[1][j] = 32'((t1 + 44'sd2048) >>> 12);
            n_k[2][j] = 32'((t2 + 44'sd2048) >>> 12);
        end
    end

    always_ff @(posedge i_clk) begin
        r_k <= n_k;
    end

    // valid bits
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v     <= '0;
            o_valid <= 1'b0;
        end else if (en) begin
            r_v     <= {r_v[NS-2:0], accept};
            o_valid <= r_v[NS-1] && !r_pl[NS-1].is_wr;
        end
    end

    // transaction side-band
    always_ff @(posedge i_clk) begin
        if (en) begin
            r_pl[0].is_wr <= !i_req_type;
            r_pl[0].fwd   <= i_point_x >= r_min_fwd;
            r_pl[0].fe    <= i_frame_end;
            r_pl[0].x     <= i_point_x;
            r_pl[0].y     <= i_point_y;
            r_pl[0].z     <= i_point_z;
            r_pl[0].wcol  <= i_write_col;
            r_pl[0].wrow  <= i_write_row;
            r_pl[0].rgb   <= {i_write_red, i_write_green, i_write_blue};
            for (int i = 1; i < NS; i++) begin
                r_pl[i] <= r_pl[i-1];
            end
        end
    end

    // products, sums, magnitudes
    always_ff @(posedge i_clk) begin
        if (en) begin
            for (int r = 0; r < 3; r++) begin
                r_prod[r][0] <= 64'(r_k[r][0]) * 64'(r_pl[0].x);
                r_prod[r][1] <= 64'(r_k[r][1]) * 64'(r_pl[0].y);
                r_prod[r][2] <= 64'(r_k[r][2]) * 64'(r_pl[0].z);
                r_n[r] <= r_prod[r][0] + r_prod[r][1] + r_prod[r][2]
                        + (64'(r_k[r][3]) <<< 16);
            end
            r_neg0 <= r_n[0][63];
            r_neg1 <= r_n[1][63];
            r_a0   <= r_n[0][63] ? 64'(-r_n[0]) : 64'(r_n[0]);
            r_a1   <= r_n[1][63] ? 64'(-r_n[1]) : 64'(r_n[1]);
            r_d    <= 64'(r_n[2]);
            r_pos  <= (r_n[2] > 64'sd0) && r_pl[2].fwd;
        end
    end

    // quotient range precheck, then restoring division one quotient bit per stage
    always_ff @(posedge i_clk) begin
        logic [DW-1:0] dv;
        logic          ge0, ge1;
        if (en) begin
            r_rem0[0] <= r_a0;
            r_rem1[0] <= r_a1;
            r_q0[0]   <= '0;
            r_q1[0]   <= '0;
            r_dd[0]   <= r_d;
            r_ng0[0]  <= r_neg0;
            r_ng1[0]  <= r_neg1;
            r_ok[0]   <= r_pos
                      && ({{QB{1'b0}}, r_a0} < {r_d, {QB{1'b0}}})
                      && ({{QB{1'b0}}, r_a1} < {r_d, {QB{1'b0}}});
            for (int g = 0; g < QB; g++) begin
                dv  = DW'(r_dd[g]) << (QB - 1 - g);
                ge0 = DW'(r_rem0[g]) >= dv;
                ge1 = DW'(r_rem1[g]) >= dv;
                r_dd[g+1]   <= r_dd[g];
                r_ok[g+1]   <= r_ok[g];
                r_ng0[g+1]  <= r_ng0[g];
                r_ng1[g+1]  <= r_ng1[g];
                r_rem0[g+1] <= ge0 ? (r_rem0[g] - dv[63:0]) : r_rem0[g];
                r_rem1[g+1] <= ge1 ? (r_rem1[g] - dv[63:0]) : r_rem1[g];
                r_q0[g+1]   <= ge0 ? (r_q0[g] | (QB'(1) << (QB - 1 - g))) : r_q0[g];
                r_q1[g+1]   <= ge1 ? (r_q1[g] | (QB'(1) << (QB - 1 - g))) : r_q1[g];
            end
        end
    end

    // bounds check and pixel address
    always_ff @(posedge i_clk) begin
        logic u_ok, v_ok, in_rng;
        u_ok   = (!r_ng0[QB] || r_q0[QB] == '0) && (int'(r_q0[QB]) < IMG_WIDTH);
        v_ok   = (!r_ng1[QB] || r_q1[QB] == '0) && (int'(r_q1[QB]) < IMG_HEIGHT);
        in_rng = (int'(r_pl[NS-3].wcol) < IMG_WIDTH)
              && (int'(r_pl[NS-3].wrow) < IMG_HEIGHT);
        if (en) begin
            r_hit_a <= r_ok[QB] && u_ok && v_ok;
            r_col_a <= r_q0[QB];
            r_row_a <= r_q1[QB];
            r_we    <= r_v[NS-3] && r_pl[NS-3].is_wr && in_rng;
            if (r_pl[NS-3].is_wr) begin
                r_addr <= AW'(AW'(r_pl[NS-3].wrow) * AW'(IMG_WIDTH)
                        + AW'(r_pl[NS-3].wcol));
            end else begin
                r_addr <= AW'(AW'(r_q1[QB]) * AW'(IMG_WIDTH) + AW'(r_q0[QB]));
            end
        end
    end

    // pixel store
    always_ff @(posedge i_clk) begin
        if (en) begin
            if (r_we) begin
                mem[r_addr] <= r_pl[NS-2].rgb;
            end
            r_rd    <= mem[r_addr];
            r_hit_m <= r_hit_a;
            r_col_m <= r_col_a;
            r_row_m <= r_row_a;
        end
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (en) begin
            o_hit         <= r_hit_m;
            o_frame_done  <= r_pl[NS-1].fe;
            o_image_col   <= r_hit_m ? 10'(r_col_m) : 10'd0;
            o_image_row   <= r_hit_m ? 9'(r_row_m) : 9'd0;
            o_color_red   <= r_hit_m ? r_rd[23:16] : 8'd0;
            o_color_green <= r_hit_m ? r_rd[15:8] : 8'd0;
            o_color_blue  <= r_hit_m ? r_rd[7:0] : 8'd0;
            o_out_x       <= r_pl[NS-1].x;
            o_out_y       <= r_pl[NS-1].y;
            o_out_z       <= r_pl[NS-1].z;
        end
    end

endmodule

### rtl/lpc_checker.sv
// ----------------------------------------------------------------------------
// lpc_checker
// Port-level checks of the lidar point colouriser, bound to the top level.
// ----------------------------------------------------------------------------
module lpc_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        o_stall,
    input logic        o_valid,
    input logic        i_stall,
    input logic        o_hit,
    input logic [9:0]  o_image_col,
    input logic [8:0]  o_image_row,
    input logic [7:0]  o_color_red,
    input logic [7:0]  o_color_green,
    input logic [7:0]  o_color_blue,
    input logic        o_cfg_ready
);

    a_stall_follows_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_stall == (o_valid && i_stall))
        else $error("input stall not tied to a blocked result");

    a_miss_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !o_hit) |-> (o_image_col == 10'd0 && o_image_row == 9'd0
            && o_color_red == 8'd0 && o_color_green == 8'd0 && o_color_blue == 8'd0))
        else $error("miss carries pixel data");

    a_result_held: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && i_stall) |=> (o_valid && $stable(o_hit) && $stable(o_image_col)))
        else $error("stalled result changed");

    a_cfg_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cfg_ready)
        else $error("config port not ready");

endmodule

bind lidar_point_camera_colorize_top lpc_checker u_lpc_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .o_stall       (o_stall),
    .o_valid       (o_valid),
    .i_stall       (i_stall),
    .o_hit         (o_hit),
    .o_image_col   (o_image_col),
    .o_image_row   (o_image_row),
    .o_color_red   (o_color_red),
    .o_color_green (o_color_green),
    .o_color_blue  (o_color_blue),
    .o_cfg_ready   (o_cfg_ready)
);
